### sv/sbpd_pkg.sv
// Shared types, codes and sizes of the double-size sprite blitter.
// Used by the other files of the block but sbpd_ram and sbpd_checker; depends on nothing.
`default_nettype none

package sbpd_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

  localparam int POS_W    = 12;
  localparam int SIZE_W   = 10;
  localparam int IDX_W    = 8;
  localparam int RGB_W    = 24;
  localparam int ADDR_W   = 32;
  localparam int STRIDE_W = 14;
  localparam int SCREEN_W = 12;
  localparam int ORG_W    = POS_W + 1;
  localparam int CRD_W    = ORG_W + 1;
  localparam int VIS_W    = SCREEN_W - 1;
  localparam int PROD_W   = STRIDE_W + VIS_W + 1;

  localparam int QDEPTH  = 4;
  localparam int Q_AW    = $clog2(QDEPTH);
  localparam int QCNT_W  = Q_AW + 1;

  typedef logic [1:0] op_t;
  localparam op_t OP_PALETTE = 2'd0;
  localparam op_t OP_BEGIN   = 2'd1;
  localparam op_t OP_PIXEL   = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FRAME_BASE = 2'd0;
  localparam cfg_idx_t CFG_ROW_STRIDE = 2'd1;
  localparam cfg_idx_t CFG_SCREEN_W   = 2'd2;
  localparam cfg_idx_t CFG_SCREEN_H   = 2'd3;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 14'd640;
  localparam logic [SCREEN_W-1:0] SCR_W_RESET  = 12'd640;
  localparam logic [SCREEN_W-1:0] SCR_H_RESET  = 12'd480;

  typedef logic [1:0] beat_t;
  localparam beat_t BEAT_LAST = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]   frame_base;
    logic [STRIDE_W-1:0] row_stride;
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic             draw;
    logic [VIS_W-1:0] px;
    logic [VIS_W-1:0] py;
  } pix_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_addr;
    logic [RGB_W-1:0]  rgb;
  } wr_t;

  function automatic logic in_palette(logic [IDX_W-1:0] idx);
    return (IDX_W + 1)'(idx) < (IDX_W + 1)'(PALETTE_ENTRIES);
  endfunction

endpackage

`default_nettype wire

### sv/sbpd_in_if.sv
// Input channel of the sprite blitter: palette writes, begin and pixel items.
// Depends on sbpd_pkg.
`default_nettype none

interface sbpd_in_if;
  import sbpd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [SIZE_W-1:0]        hot_x;
  logic [SIZE_W-1:0]        hot_y;
  logic [SIZE_W-1:0]        sprite_width;
  logic [SIZE_W-1:0]        sprite_height;
  logic [IDX_W-1:0]         palette_index;
  logic [RGB_W-1:0]         palette_rgb;
  logic [IDX_W-1:0]         color_index;

  modport source (output valid, operation, pos_x, pos_y, hot_x, hot_y, sprite_width,
                  sprite_height, palette_index, palette_rgb, color_index,
                  input ready);
  modport sink   (input valid, operation, pos_x, pos_y, hot_x, hot_y, sprite_width,
                  sprite_height, palette_index, palette_rgb, color_index,
                  output ready);
endinterface

`default_nettype wire

### sv/sbpd_out_if.sv
// Output channel of the sprite blitter: framebuffer word writes.
// Depends on sbpd_pkg.
`default_nettype none

interface sbpd_out_if;
  import sbpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_address;
  logic [RGB_W-1:0]  write_color;
  logic              last;

  modport source (output valid, write_address, write_color, last, input ready);
  modport sink   (input valid, write_address, write_color, last, output ready);
endinterface

`default_nettype wire

### sv/sbpd_ram.sv
// Generic single-port synchronous RAM, read-before-write, registered read.
// No dependencies.
`default_nettype none

module sbpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end
endmodule

`default_nettype wire

### sv/sbpd_front.sv
// Input stage: sprite origin and counters, clip test, palette RAM access.
// Depends on sbpd_pkg, sbpd_in_if and sbpd_ram.
`default_nettype none

module sbpd_front (
  input  logic                         clk,
  input  logic                         rst,
  sbpd_in_if.sink                      items,
  input  logic                         can_take,
  input  sbpd_pkg::cfg_t               cfg,
  output sbpd_pkg::pix_t               pix_b,
  output logic [sbpd_pkg::RGB_W-1:0]   pal_rgb
);
  import sbpd_pkg::*;

  logic                    acc;
  logic signed [ORG_W-1:0] org_x;
  logic signed [ORG_W-1:0] org_y;
  logic [SIZE_W-1:0]       width_held;
  logic [SIZE_W-1:0]       height_held;
  logic [SIZE_W-1:0]       col;
  logic [SIZE_W-1:0]       row;
  logic [SIZE_W:0]         col_inc;
  logic                    active;
  logic [CRD_W-1:0]        px;
  logic [CRD_W-1:0]        py;
  logic                    vis_x;
  logic                    vis_y;
  logic                    draw;
  logic                    ram_we;
  logic [PAL_AW-1:0]       ram_addr;

  assign items.ready = can_take;
  assign acc         = items.valid && items.ready;

  assign active  = (width_held != '0) && (row < height_held);
  assign col_inc = (SIZE_W + 1)'(col) + (SIZE_W + 1)'(1);

  assign px = {org_x[ORG_W-1], org_x} + CRD_W'(col);
  assign py = {org_y[ORG_W-1], org_y} + CRD_W'(row);

  // visible when 0 <= p and 2p + 2 <= screen size
  assign vis_x = !px[CRD_W-1] &&
                 (px[CRD_W-2:0] < (CRD_W - 1)'(cfg.screen_width[SCREEN_W-1:1]));
  assign vis_y = !py[CRD_W-1] &&
                 (py[CRD_W-2:0] < (CRD_W - 1)'(cfg.screen_height[SCREEN_W-1:1]));
  assign draw  = active && vis_x && vis_y && (items.color_index != '0) &&
                 in_palette(items.color_index);

  assign ram_we   = acc && (items.operation == OP_PALETTE) && in_palette(items.palette_index);
  assign ram_addr = (items.operation == OP_PALETTE) ? items.palette_index[PAL_AW-1:0]
                                                    : items.color_index[PAL_AW-1:0];

  sbpd_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .en    (acc),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (items.palette_rgb),
    .rdata (pal_rgb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      org_x       <= '0;
      org_y       <= '0;
      width_held  <= '0;
      height_held <= '0;
      col         <= '0;
      row         <= '0;
      pix_b.draw  <= 1'b0;
    end else begin
      pix_b.draw <= acc && (items.operation == OP_PIXEL) && draw;
      pix_b.px   <= px[VIS_W-1:0];
      pix_b.py   <= py[VIS_W-1:0];
      if (acc) begin
        unique case (items.operation)
          OP_BEGIN: begin
            org_x       <= {items.pos_x[POS_W-1], items.pos_x} - ORG_W'(items.hot_x);
            org_y       <= {items.pos_y[POS_W-1], items.pos_y} - ORG_W'(items.hot_y);
            width_held  <= items.sprite_width;
            height_held <= items.sprite_height;
            col         <= '0;
            row         <= '0;
          end
          OP_PIXEL: begin
            if (active) begin
              if (col_inc >= (SIZE_W + 1)'(width_held)) begin
                col <= '0;
                row <= row + 1'b1;
              end else begin
                col <= col_inc[SIZE_W-1:0];
              end
            end
          end
          default: ;
        endcase
      end
    end
  end
endmodule

`default_nettype wire

### sv/sbpd_addr.sv
// Address stages: row offset multiply, then base address sum of each drawn pixel.
// Depends on sbpd_pkg.
`default_nettype none

module sbpd_addr (
  input  logic                     clk,
  input  logic                     rst,
  input  sbpd_pkg::cfg_t           cfg,
  input  sbpd_pkg::pix_t           pix_b,
  input  logic [sbpd_pkg::RGB_W-1:0] pal_rgb,
  output logic                     push,
  output sbpd_pkg::wr_t            push_data,
  output logic [1:0]               in_flight
);
  import sbpd_pkg::*;

  logic              c_draw;
  logic [VIS_W-1:0]  c_px;
  logic [PROD_W-1:0] c_prod;
  logic [RGB_W-1:0]  c_rgb;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(cfg.row_stride) * PROD_W'({pix_b.py, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      c_draw <= 1'b0;
    end else begin
      c_draw <= pix_b.draw;
      c_px   <= pix_b.px;
      c_prod <= prod;
      c_rgb  <= pal_rgb;
    end
  end

  assign push                = c_draw;
  assign push_data.base_addr = cfg.frame_base + ADDR_W'(c_prod) + ADDR_W'({c_px, 1'b0});
  assign push_data.rgb       = c_rgb;
  assign in_flight           = 2'(pix_b.draw) + 2'(c_draw);
endmodule

`default_nettype wire

### sv/sbpd_wqueue.sv
// Pixel queue and write sequencer: four word writes per queued pixel.
// Depends on sbpd_pkg and sbpd_out_if.
`default_nettype none

module sbpd_wqueue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  sbpd_pkg::wr_t                 push_data,
  input  logic [sbpd_pkg::STRIDE_W-1:0] stride,
  sbpd_out_if.source                    writes,
  output logic [sbpd_pkg::QCNT_W-1:0]   count
);
  import sbpd_pkg::*;

  wr_t             q [QDEPTH];
  logic [Q_AW-1:0] wptr;
  logic [Q_AW-1:0] rptr;
  beat_t           beat;
  wr_t             head;
  logic            fire;
  logic            pop;

  assign head                 = q[rptr];
  assign writes.valid         = (count != '0);
  assign writes.write_address = head.base_addr + (beat[1] ? ADDR_W'(stride) : '0) +
                                ADDR_W'(beat[0]);
  assign writes.write_color   = head.rgb;
  assign writes.last          = (beat == BEAT_LAST);

  assign fire = writes.valid && writes.ready;
  assign pop  = fire && writes.last;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      beat  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (fire) begin
        beat <= beat + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end
endmodule

`default_nettype wire

### sv/sprite_blit_pixel_double_top.sv
// Double-size palettized sprite blitter, top level.
// Input channel "items" takes palette writes, sprite begins and source pixels.
// Output channel "writes" gives framebuffer word writes; each drawn pixel
// yields four writes (2x2 block), the fourth flagged by last.
// The cfg port writes frame base, row stride and screen size; the user must
// write it only while idle, the block does not enforce it. The first write
// of a pixel is valid after the registered RAM read, multiply and queue sum.
// Throughput: one item per cycle while nothing is drawn and the queue has room;
// drawn pixels are bounded by the write port at one word per cycle while ready.
// A four-entry pixel queue with credit counting sets when items stops taking.
// Reset clears the counters, the sprite state and the queue; the palette
// holds garbage until written. A stalled writes channel holds its item and,
// once the queue and pipeline fill, stalls items.
// Depends on sbpd_pkg, sbpd_in_if, sbpd_out_if and the sbpd_* modules.
`default_nettype none

module sprite_blit_pixel_double_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sbpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbpd_pkg::CFG_DATA_W-1:0]   cfg_data,
  sbpd_in_if.sink                           items,
  sbpd_out_if.source                        writes
);
  import sbpd_pkg::*;

  cfg_t              cfg;
  pix_t              pix_b;
  logic [RGB_W-1:0]  pal_rgb;
  logic              push;
  wr_t               push_data;
  logic [1:0]        in_flight;
  logic [QCNT_W-1:0] count;
  logic              can_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_base    <= '0;
      cfg.row_stride    <= STRIDE_RESET;
      cfg.screen_width  <= SCR_W_RESET;
      cfg.screen_height <= SCR_H_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_BASE: cfg.frame_base    <= cfg_data[ADDR_W-1:0];
        CFG_ROW_STRIDE: cfg.row_stride    <= cfg_data[STRIDE_W-1:0];
        CFG_SCREEN_W:   cfg.screen_width  <= cfg_data[SCREEN_W-1:0];
        CFG_SCREEN_H:   cfg.screen_height <= cfg_data[SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign can_take = ((QCNT_W + 1)'(count) + (QCNT_W + 1)'(in_flight)) <
                    (QCNT_W + 1)'(QDEPTH);

  sbpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .can_take (can_take),
    .cfg      (cfg),
    .pix_b    (pix_b),
    .pal_rgb  (pal_rgb)
  );

  sbpd_addr u_addr (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_b     (pix_b),
    .pal_rgb   (pal_rgb),
    .push      (push),
    .push_data (push_data),
    .in_flight (in_flight)
  );

  sbpd_wqueue u_wqueue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .stride    (cfg.row_stride),
    .writes    (writes),
    .count     (count)
  );
endmodule

`default_nettype wire

### sv/sbpd_checker.sv
// Port-level checks of the sprite blitter's write channel, bound to the top.
// Depends on sprite_blit_pixel_double_top and sbpd_out_if.
`default_nettype none

module sbpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [31:0] out_address,
  input logic [23:0] out_color
);
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("write valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_address) &&
                                $stable(out_color) && $stable(out_last))
    else $error("stalled write changed");

  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("pixel burst broken before last write");

  a_burst_color: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_color == $past(out_color))
    else $error("color changed inside a pixel burst");

  a_last_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_last)
    else $error("last held past the fourth write of a pixel");
endmodule

bind sprite_blit_pixel_double_top sbpd_checker u_sbpd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (writes.valid),
  .out_ready   (writes.ready),
  .out_last    (writes.last),
  .out_address (writes.write_address),
  .out_color   (writes.write_color)
);

`default_nettype wire
